FILE: rtl/core/rhc_pkg.sv
// Shared types and constants of the roaming handoff controller.
package rhc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ_CUR,
        ST_CHECK,
        ST_MOD,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_ANT      = 2'd1,
        MODE_INACTIVE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ACT_UPLINK   = 2'd0,
        ACT_CONTROL  = 2'd1,
        ACT_DOWNLINK = 2'd2,
        ACT_BEACON   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_CLIENT_NUMBER  = 3'd0,
        CFG_START_AP       = 3'd1,
        CFG_MANUAL_PERIOD  = 3'd2,
        CFG_HOLD_TIME      = 3'd3,
        CFG_ROAM_THRESHOLD = 3'd4
    } t_cfg_idx;

    localparam logic [7:0] MSG_REQUEST    = 8'h04;
    localparam logic [7:0] MSG_REASSOC    = 8'h0a;
    localparam logic [7:0] MSG_HANDOFF_GO = 8'h09;
    localparam logic [7:0] MSG_RESUME     = 8'h0d;

    localparam logic signed [7:0] RSSI_UNHEARD = -8'sd127;

    localparam int DVD_W          = 32;
    localparam int DIV_W          = 16;
    localparam int MOD_BITS_CYCLE = 2;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_mod_status;

endpackage

FILE: rtl/core/roaming_handoff_controller_unit.sv
// Roaming handoff controller top level: sequencer, RSSI table and output register.
//
// One item at a time; o_in_ready is high only while the sequencer is idle. A data item or
// an accepted handoff-go message is staged in the result registers and then moves to the
// output register once that is free. A beacon goes through the table write, the current-AP
// read and the hold check; a manual-mode decision then waits on the remainder unit (16
// steps of two bits of the beacon count), and an RSSI search walks the table through its
// single read port. A handoff request then goes through the result registers to the output.
// The output register holds a result until taken while the next item is accepted. Table
// entries carry valid bits cleared by reset, so no clearing pass follows reset.
module roaming_handoff_controller_unit import rhc_pkg::*; #(
    parameter int AP_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_msg_type,
    input  logic [7:0]        i_msg_client,
    input  logic [7:0]        i_msg_orig_ap,
    input  logic [7:0]        i_msg_target_ap,
    input  logic [2:0]        i_report_client,
    input  logic [3:0]        i_report_ap,
    input  logic signed [7:0] i_report_rssi,
    input  logic [31:0]       i_time_ms,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_send_message,
    output logic [7:0]        o_out_code,
    output logic [7:0]        o_out_client,
    output logic [7:0]        o_out_orig_ap,
    output logic [7:0]        o_out_target_ap,
    output logic              o_forward_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    localparam int IW = $clog2(AP_COUNT);
    localparam int CW = (IW > 3) ? IW : 3;

    localparam logic [2:0]        CLIENT_RESET = 3'd1;
    localparam logic [15:0]       HOLD_RESET   = 16'd1000;
    localparam logic signed [7:0] THRESH_RESET = -8'sd68;

    t_state r_state, n_state;
    t_mode  r_mode;

    logic [2:0]        r_client_number;
    logic [15:0]       r_manual_period;
    logic [15:0]       r_hold_time;
    logic signed [7:0] r_threshold;

    logic [CW-1:0]     r_cur;
    logic [CW-1:0]     r_pick;
    logic              r_hold;
    logic [31:0]       r_last_switch;
    logic [31:0]       r_beacon_count;
    logic [2:0]        r_last_client;

    logic [3:0]        r_ap;
    logic signed [7:0] r_rs;
    logic [31:0]       r_now;

    logic signed [7:0] r_mem [AP_COUNT];
    logic [AP_COUNT-1:0] r_mem_vld;
    logic signed [7:0] r_rd_data;
    logic              r_rd_vld;

    logic [IW:0]       r_idx;
    logic [IW-1:0]     r_pidx;
    logic              r_pend;
    logic signed [7:0] r_best;

    logic              r_res_send;
    logic [7:0]        r_res_code;
    logic [7:0]        r_res_client;
    logic [7:0]        r_res_orig;
    logic [7:0]        r_res_target;
    logic              r_res_fwd;

    logic              r_out_valid;
    logic              r_o_send;
    logic [7:0]        r_o_code;
    logic [7:0]        r_o_client;
    logic [7:0]        r_o_orig;
    logic [7:0]        r_o_target;
    logic              r_o_fwd;

    logic              in_fire;
    logic              cfg_fire;
    t_action           act;
    logic [2:0]        lc_new;
    logic              ap_ok;
    logic              cur_in_tab;
    logic signed [7:0] cur_rssi;
    logic              unheard;
    logic              expired;
    logic              hold_next;
    logic              blocked;
    logic              manual;
    logic              keep;
    logic              scan_issue;
    logic signed [7:0] scan_e;
    logic              is_go;
    logic              is_resume;

    logic              mem_we;
    logic              mem_re;
    logic [IW-1:0]     mem_waddr;
    logic [IW-1:0]     mem_raddr;
    logic              mod_start;
    logic              out_load;
    t_mod_status       mod_st;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid & o_in_ready;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;
    assign act         = t_action'(i_action);

    assign lc_new     = (i_report_client >= 3'd1 && i_report_client <= 3'd4) ?
                        i_report_client : r_last_client;
    assign is_go      = (r_mode == MODE_ANT) && (i_msg_type == MSG_HANDOFF_GO);
    assign is_resume  = (r_mode == MODE_INACTIVE) && (i_msg_type == MSG_RESUME);

    assign ap_ok      = (r_ap != 4'd0) && (32'(r_ap) <= AP_COUNT);
    assign mem_waddr  = IW'(r_ap - 4'd1);
    assign cur_in_tab = (32'(r_cur) < AP_COUNT);
    assign cur_rssi   = (cur_in_tab && r_rd_vld) ? r_rd_data : RSSI_UNHEARD;
    assign unheard    = (cur_rssi == RSSI_UNHEARD);
    assign expired    = ((r_now - r_last_switch) > {16'd0, r_hold_time});
    assign hold_next  = r_hold & ~expired;
    assign blocked    = (r_mode != MODE_IDLE) || hold_next;
    assign manual     = (r_manual_period != 16'd0);
    assign keep       = (cur_rssi >= r_threshold);
    assign scan_issue = (32'(r_idx) < AP_COUNT);
    assign scan_e     = r_rd_vld ? r_rd_data : RSSI_UNHEARD;

    rhc_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_beacon_count + 32'd1),
        .i_divisor  (r_manual_period),
        .o_status   (mod_st)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (act) inside
                        ACT_UPLINK, ACT_DOWNLINK: n_state = ST_EMIT;
                        ACT_CONTROL:              if (is_go) n_state = ST_EMIT;
                        default:                  if (lc_new == r_client_number)
                                                      n_state = ST_WRITE;
                    endcase
                end
            end
            ST_WRITE:    n_state = ST_READ_CUR;
            ST_READ_CUR: n_state = ST_CHECK;
            ST_CHECK: begin
                if (unheard || blocked) begin
                    n_state = ST_IDLE;
                end else if (manual) begin
                    n_state = ST_MOD;
                end else if (keep) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_MOD:    if (mod_st.done) n_state = ST_DECIDE;
            ST_SCAN:   if (!scan_issue && !r_pend) n_state = ST_DECIDE;
            ST_DECIDE: n_state = (r_pick == r_cur) ? ST_IDLE : ST_EMIT;
            ST_EMIT:   if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer strobes
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = r_cur[IW-1:0];
        mod_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_WRITE:    mem_we = ap_ok;
            ST_READ_CUR: mem_re = cur_in_tab;
            ST_CHECK:    mod_start = !unheard && !blocked && manual;
            ST_SCAN: begin
                mem_re    = scan_issue;
                mem_raddr = r_idx[IW-1:0];
            end
            ST_EMIT:     out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // RSSI table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_rs;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
            r_rd_vld  <= r_mem_vld[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_IDLE;
            r_client_number <= CLIENT_RESET;
            r_manual_period <= 16'd0;
            r_hold_time     <= HOLD_RESET;
            r_threshold     <= THRESH_RESET;
            r_cur           <= '0;
            r_hold          <= 1'b0;
            r_last_switch   <= 32'd0;
            r_beacon_count  <= 32'd0;
            r_last_client   <= 3'd0;
            r_mem_vld       <= '0;
            r_pend          <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CLIENT_NUMBER:  r_client_number <= i_cfg_data[2:0];
                    CFG_START_AP:       r_cur <= CW'(i_cfg_data[2:0]);
                    CFG_MANUAL_PERIOD:  r_manual_period <= i_cfg_data;
                    CFG_HOLD_TIME:      r_hold_time <= i_cfg_data;
                    CFG_ROAM_THRESHOLD: r_threshold <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (mem_we) begin
                r_mem_vld[mem_waddr] <= 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_o_send    <= r_res_send;
                r_o_code    <= r_res_code;
                r_o_client  <= r_res_client;
                r_o_orig    <= r_res_orig;
                r_o_target  <= r_res_target;
                r_o_fwd     <= r_res_fwd;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_ap  <= i_report_ap;
                        r_rs  <= i_report_rssi;
                        r_now <= i_time_ms;
                        case (act) inside
                            ACT_UPLINK, ACT_DOWNLINK: begin
                                r_res_send   <= 1'b0;
                                r_res_code   <= 8'd0;
                                r_res_client <= 8'd0;
                                r_res_orig   <= 8'd0;
                                r_res_target <= 8'd0;
                                r_res_fwd    <= (r_mode != MODE_INACTIVE);
                            end
                            ACT_CONTROL: begin
                                if (is_go) begin
                                    r_mode       <= MODE_INACTIVE;
                                    r_res_send   <= 1'b1;
                                    r_res_code   <= MSG_REASSOC;
                                    r_res_client <= i_msg_client;
                                    r_res_orig   <= i_msg_orig_ap;
                                    r_res_target <= i_msg_target_ap;
                                    r_res_fwd    <= 1'b0;
                                end else if (is_resume) begin
                                    r_mode <= MODE_IDLE;
                                end
                            end
                            default: r_last_client <= lc_new;
                        endcase
                    end
                end
                ST_CHECK: begin
                    if (!unheard) begin
                        r_beacon_count <= r_beacon_count + 32'd1;
                        r_hold         <= hold_next;
                    end
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    r_best <= RSSI_UNHEARD;
                    r_pick <= r_cur;
                end
                ST_MOD: begin
                    if (mod_st.done) begin
                        r_pick <= mod_st.rem_zero ? {{(CW-1){1'b0}}, ~r_cur[0]} : r_cur;
                    end
                end
                ST_SCAN: begin
                    r_pend <= scan_issue;
                    r_pidx <= r_idx[IW-1:0];
                    if (scan_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_pend && (scan_e > r_best)) begin
                        r_best <= scan_e;
                        r_pick <= CW'(r_pidx);
                    end
                end
                ST_DECIDE: begin
                    if (r_pick != r_cur) begin
                        r_res_send    <= 1'b1;
                        r_res_code    <= MSG_REQUEST;
                        r_res_client  <= {5'd0, r_client_number} - 8'd1;
                        r_res_orig    <= 8'(r_cur);
                        r_res_target  <= 8'(r_pick);
                        r_res_fwd     <= 1'b0;
                        r_cur         <= r_pick;
                        r_mode        <= MODE_ANT;
                        r_hold        <= 1'b1;
                        r_last_switch <= r_now;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_send_message  = r_o_send;
    assign o_out_code      = r_o_code;
    assign o_out_client    = r_o_client;
    assign o_out_orig_ap   = r_o_orig;
    assign o_out_target_ap = r_o_target;
    assign o_forward_data  = r_o_fwd;

endmodule

FILE: rtl/core/rhc_mod_unit.sv
// Iterative remainder unit: beacon count modulo manual period, two bits per cycle.
module rhc_mod_unit import rhc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output t_mod_status      o_status
);

    localparam int STEPS = DVD_W / MOD_BITS_CYCLE;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] n_rem;
    logic [DVD_W-1:0] n_dvd;

    always_comb begin
        logic [DIV_W:0]   sh;
        logic [DIV_W-1:0] rem_v;
        logic [DVD_W-1:0] dvd_v;
        rem_v = r_rem;
        dvd_v = r_dvd;
        for (int k = 0; k < MOD_BITS_CYCLE; k++) begin
            sh = {rem_v, dvd_v[DVD_W-1]};
            dvd_v = {dvd_v[DVD_W-2:0], 1'b0};
            if (sh >= {1'b0, r_div}) begin
                sh = sh - {1'b0, r_div};
            end
            rem_v = sh[DIV_W-1:0];
        end
        n_rem = rem_v;
        n_dvd = dvd_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

FILE: rtl/core/rhc_checker.sv
// Port-level assertions for the roaming handoff controller, bound to the top level.
module rhc_port_checker import rhc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_send_message,
    input logic [7:0] o_out_code,
    input logic [7:0] o_out_client,
    input logic [7:0] o_out_orig_ap,
    input logic [7:0] o_out_target_ap,
    input logic       o_forward_data
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_msg_not_forwarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_message |-> !o_forward_data)
        else $error("message item marked as forwarded data");

    a_msg_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_message |->
            (o_out_code == MSG_REQUEST || o_out_code == MSG_REASSOC))
        else $error("unexpected message code");

    a_data_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_send_message |->
            (o_out_code == 8'd0 && o_out_client == 8'd0 &&
             o_out_orig_ap == 8'd0 && o_out_target_ap == 8'd0))
        else $error("data item carries message fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_code) && $stable(o_forward_data))
        else $error("stalled item changed");

endmodule

bind roaming_handoff_controller_unit rhc_port_checker u_rhc_checker (.*);

FILE: tb/rhc_checker.sv
// Checker for the roaming handoff controller: predicts each result and compares it on arrival.
`timescale 1ns / 100ps

module rhc_checker #(
    parameter int AP_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_msg_type,
    input  logic [7:0]        i_msg_client,
    input  logic [7:0]        i_msg_orig_ap,
    input  logic [7:0]        i_msg_target_ap,
    input  logic [2:0]        i_report_client,
    input  logic [3:0]        i_report_ap,
    input  logic signed [7:0] i_report_rssi,
    input  logic [31:0]       i_time_ms,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic              i_send_message,
    input  logic [7:0]        i_out_code,
    input  logic [7:0]        i_out_client,
    input  logic [7:0]        i_out_orig_ap,
    input  logic [7:0]        i_out_target_ap,
    input  logic              i_forward_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output int                o_mismatches,
    output int                o_pending
);
    import rhc_pkg::*;

    typedef struct packed {
        logic       send;
        logic [7:0] code, client, orig, target;
        logic       fwd;
    } t_result;

    localparam logic [2:0]         DEF_CLIENT    = 3'd1;
    localparam logic [15:0]        DEF_HOLD_MS   = 16'd1000;
    localparam logic signed [7:0]  DEF_THRESHOLD = -8'sd68;

    // configuration copy
    logic [2:0]        client_num;
    logic [15:0]       switch_period;
    logic [15:0]       hold_ms;
    logic signed [7:0] roam_thr;

    // controller state copy
    t_mode             mode;
    logic signed [7:0] rssi_seen [AP_COUNT];
    logic [2:0]        cur_ap;
    logic              hold_on;
    logic [31:0]       last_switch;
    logic [31:0]       beacon_cnt;
    logic [2:0]        last_client;

    t_result expected_msgs [$];
    int      mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic logic signed [7:0] rssi_of(input logic [2:0] idx);
        return (int'(idx) < AP_COUNT) ? rssi_seen[idx] : RSSI_UNHEARD;
    endfunction

    task automatic predict_roaming(
        input t_action           act,
        input logic [7:0]        mtype,
        input logic [7:0]        mc,
        input logic [7:0]        mo,
        input logic [7:0]        mt,
        input logic [2:0]        rc,
        input logic [3:0]        ap,
        input logic signed [7:0] rs,
        input logic [31:0]       now
    );
        t_result           res;
        logic [2:0]        pick;
        logic signed [7:0] best;
        logic [31:0]       elapsed;
        int                i;
        res = '0;
        case (act)
            ACT_UPLINK, ACT_DOWNLINK: begin
                res.fwd = (mode != MODE_INACTIVE);
                expected_msgs.push_back(res);
            end
            ACT_CONTROL: begin
                if (mode == MODE_ANT && mtype == MSG_HANDOFF_GO) begin
                    mode = MODE_INACTIVE;
                    res = '{send: 1'b1, code: MSG_REASSOC, client: mc, orig: mo,
                            target: mt, fwd: 1'b0};
                    expected_msgs.push_back(res);
                end else if (mode == MODE_INACTIVE && mtype == MSG_RESUME) begin
                    mode = MODE_IDLE;
                end
            end
            default: begin
                if (rc >= 3'd1 && rc <= 3'd4)
                    last_client = rc;
                if (last_client != client_num)
                    return;
                if (ap >= 4'd1 && int'(ap) <= AP_COUNT)
                    rssi_seen[ap - 4'd1] = rs;
                if (rssi_of(cur_ap) == RSSI_UNHEARD)
                    return;
                beacon_cnt = beacon_cnt + 32'd1;
                elapsed = now - last_switch;
                if (elapsed > {16'd0, hold_ms})
                    hold_on = 1'b0;
                if (mode != MODE_IDLE || hold_on)
                    return;
                pick = cur_ap;
                if (switch_period != 16'd0) begin
                    if (beacon_cnt % {16'd0, switch_period} == 32'd0)
                        pick = {2'b00, ~cur_ap[0]};
                end else begin
                    if (rssi_of(cur_ap) >= roam_thr)
                        return;
                    best = RSSI_UNHEARD;
                    for (i = 0; i < AP_COUNT; i++) begin
                        if (rssi_seen[i] > best) begin
                            best = rssi_seen[i];
                            pick = 3'(i);
                        end
                    end
                end
                if (pick == cur_ap)
                    return;
                res = '{send: 1'b1, code: MSG_REQUEST, client: {5'd0, client_num} - 8'd1,
                        orig: {5'd0, cur_ap}, target: {5'd0, pick}, fwd: 1'b0};
                expected_msgs.push_back(res);
                cur_ap = pick;
                mode = MODE_ANT;
                hold_on = 1'b1;
                last_switch = now;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            client_num = DEF_CLIENT;
            switch_period = '0;
            hold_ms = DEF_HOLD_MS;
            roam_thr = DEF_THRESHOLD;
            mode = MODE_IDLE;
            for (int k = 0; k < AP_COUNT; k++)
                rssi_seen[k] = RSSI_UNHEARD;
            cur_ap = '0;
            hold_on = 1'b0;
            last_switch = '0;
            beacon_cnt = '0;
            last_client = '0;
            expected_msgs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CLIENT_NUMBER:  client_num = i_cfg_data[2:0];
                    CFG_START_AP:       cur_ap = i_cfg_data[2:0];
                    CFG_MANUAL_PERIOD:  switch_period = i_cfg_data;
                    CFG_HOLD_TIME:      hold_ms = i_cfg_data;
                    CFG_ROAM_THRESHOLD: roam_thr = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_msgs.size() == 0) begin
                    $display("%0t unexpected result: expected none actual code %h fwd %b",
                             $time, i_out_code, i_forward_data);
                    mismatches++;
                end else begin
                    want = expected_msgs.pop_front();
                    check_field("send_message", {7'd0, want.send}, {7'd0, i_send_message});
                    check_field("out_code", want.code, i_out_code);
                    check_field("out_client", want.client, i_out_client);
                    check_field("out_orig_ap", want.orig, i_out_orig_ap);
                    check_field("out_target_ap", want.target, i_out_target_ap);
                    check_field("forward_data", {7'd0, want.fwd}, {7'd0, i_forward_data});
                end
            end
            if (i_in_valid && i_in_ready)
                predict_roaming(t_action'(i_action), i_msg_type, i_msg_client, i_msg_orig_ap,
                                i_msg_target_ap, i_report_client, i_report_ap,
                                i_report_rssi, i_time_ms);
        end
        o_pending <= expected_msgs.size();
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the roaming handoff controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import rhc_pkg::*;

    localparam int         SETTLE_CYCLES  = 40;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         IDLE_PCT       = 15;
    localparam logic [2:0] CFG_SPARE_IDX  = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_action = '0;
    logic [7:0]        i_msg_type = '0;
    logic [7:0]        i_msg_client = '0;
    logic [7:0]        i_msg_orig_ap = '0;
    logic [7:0]        i_msg_target_ap = '0;
    logic [2:0]        i_report_client = '0;
    logic [3:0]        i_report_ap = '0;
    logic signed [7:0] i_report_rssi = '0;
    logic [31:0]       i_time_ms = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_send_message;
    logic [7:0]        o_out_code;
    logic [7:0]        o_out_client;
    logic [7:0]        o_out_orig_ap;
    logic [7:0]        o_out_target_ap;
    logic              o_forward_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index = '0;
    logic [15:0]       i_cfg_data = '0;

    int          mismatch_count;
    int          msgs_pending;
    logic        gaps_on = 1'b1;
    logic [31:0] now_ms = 32'd5000;
    int          stall_cycles = 0;

    roaming_handoff_controller_unit u_dut (.*);

    rhc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_msg_type     (i_msg_type),
        .i_msg_client   (i_msg_client),
        .i_msg_orig_ap  (i_msg_orig_ap),
        .i_msg_target_ap(i_msg_target_ap),
        .i_report_client(i_report_client),
        .i_report_ap    (i_report_ap),
        .i_report_rssi  (i_report_rssi),
        .i_time_ms      (i_time_ms),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_send_message (o_send_message),
        .i_out_code     (o_out_code),
        .i_out_client   (o_out_client),
        .i_out_orig_ap  (o_out_orig_ap),
        .i_out_target_ap(o_out_target_ap),
        .i_forward_data (o_forward_data),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatch_count),
        .o_pending      (msgs_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= gaps_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(
        input t_action     act,
        input logic [7:0]  mtype,
        input logic [7:0]  mc,
        input logic [7:0]  mo,
        input logic [7:0]  mt,
        input logic [2:0]  rc,
        input logic [3:0]  ap,
        input logic [7:0]  rssi,
        input logic [31:0] tms
    );
        if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_msg_type <= mtype;
        i_msg_client <= mc;
        i_msg_orig_ap <= mo;
        i_msg_target_ap <= mt;
        i_report_client <= rc;
        i_report_ap <= ap;
        i_report_rssi <= rssi;
        i_time_ms <= tms;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes; caller lowers it
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (msgs_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_item(input logic [2:0] own_client);
        int          pick;
        int          rssi_v;
        logic [31:0] step_ms;
        t_action     act;
        logic [7:0]  mtype;
        logic [2:0]  rc;
        logic [3:0]  ap;
        logic [7:0]  rssi;
        pick = $urandom_range(0, 99);
        step_ms = ($urandom_range(0, 9) == 0) ? $urandom_range(1000, 80000)
                                              : $urandom_range(0, 400);
        now_ms = now_ms + step_ms;
        mtype = 8'($urandom);
        rc = 3'($urandom);
        ap = 4'($urandom);
        rssi = 8'($urandom);
        act = ACT_BEACON;
        if (pick < 50) begin
            if ($urandom_range(0, 9) < 8)
                rc = (own_client >= 3'd1 && own_client <= 3'd4) ? own_client
                                                                : 3'($urandom_range(1, 4));
            if ($urandom_range(0, 9) < 9)
                ap = 4'($urandom_range(1, 8));
            if ($urandom_range(0, 4) != 0) begin
                rssi_v = $urandom_range(0, 80);
                rssi_v = rssi_v - 110;
                rssi = rssi_v[7:0];
            end
        end else if (pick < 65) begin
            act = ACT_CONTROL;
            mtype = MSG_HANDOFF_GO;
        end else if (pick < 78) begin
            act = ACT_CONTROL;
            mtype = MSG_RESUME;
        end else if (pick < 83) begin
            act = ACT_CONTROL;
        end else begin
            act = ($urandom_range(0, 1) == 0) ? ACT_UPLINK : ACT_DOWNLINK;
        end
        send_item(act, mtype, 8'($urandom), 8'($urandom), 8'($urandom), rc, ap, rssi, now_ms);
    endtask

    task automatic run_phase(
        input logic [2:0]  client,
        input logic [2:0]  first_ap,
        input logic [15:0] period,
        input logic [15:0] hold,
        input logic [7:0]  threshold,
        input int          items,
        input logic        steady,
        input logic        wrap_time
    );
        drain();
        write_reg(CFG_CLIENT_NUMBER, {13'($urandom), client});
        write_reg(CFG_START_AP, {13'($urandom), first_ap});
        write_reg(CFG_MANUAL_PERIOD, period);
        write_reg(CFG_HOLD_TIME, hold);
        write_reg(CFG_ROAM_THRESHOLD, {8'($urandom), threshold});
        write_reg(CFG_SPARE_IDX, 16'($urandom));
        i_cfg_valid <= 1'b0;
        gaps_on <= !steady;
        if (wrap_time)
            now_ms = 32'hFFFF_FC00;
        repeat (items) random_item(client);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // client number zero: only reachable before any known beacon client
        write_reg(CFG_CLIENT_NUMBER, {13'($urandom), 3'd0});
        i_cfg_valid <= 1'b0;

        send_item(ACT_UPLINK, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 4'd0, 8'h00, 32'd0);
        send_item(ACT_DOWNLINK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 4'd15, 8'hFF, 32'hFFFF_FFFF);
        send_item(ACT_CONTROL, MSG_RESUME, 8'h12, 8'h34, 8'h56, 3'd0, 4'd0, 8'h00, 32'd5);
        send_item(ACT_CONTROL, MSG_HANDOFF_GO, 8'h12, 8'h34, 8'h56, 3'd0, 4'd0, 8'h00, 32'd6);
        // current AP heard at -127 reads as unheard
        send_item(ACT_BEACON, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 4'd1, RSSI_UNHEARD, 32'd10);
        send_item(ACT_BEACON, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5, 4'd0, 8'h00, 32'd20);
        // no AP above -127
        send_item(ACT_BEACON, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 4'd1, 8'h80, 32'd30);
        send_item(ACT_BEACON, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7, 4'd12, 8'h7F, 32'd35);
        send_item(ACT_BEACON, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 4'd2, 8'hCE, 32'd40);
        send_item(ACT_UPLINK, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 4'd0, 8'h00, 32'd41);
        send_item(ACT_CONTROL, MSG_RESUME, 8'h00, 8'h00, 8'h00, 3'd0, 4'd0, 8'h00, 32'd42);
        send_item(ACT_CONTROL, MSG_HANDOFF_GO, 8'hFF, 8'h00, 8'hAA, 3'd0, 4'd0, 8'h00, 32'd43);
        send_item(ACT_DOWNLINK, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 4'd0, 8'h00, 32'd44);
        send_item(ACT_CONTROL, MSG_HANDOFF_GO, 8'h01, 8'h02, 8'h03, 3'd0, 4'd0, 8'h00, 32'd45);
        send_item(ACT_CONTROL, MSG_RESUME, 8'h00, 8'h00, 8'h00, 3'd0, 4'd0, 8'h00, 32'd46);
        // hold still active at exactly the hold time, expires one ms later
        send_item(ACT_BEACON, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 4'd2, 8'h9C, 32'd1040);
        send_item(ACT_BEACON, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 4'd8, 8'h7F, 32'd1041);
        send_item(ACT_CONTROL, MSG_HANDOFF_GO, 8'h55, 8'hAA, 8'h0F, 3'd0, 4'd0, 8'h00, 32'd1042);
        send_item(ACT_CONTROL, MSG_RESUME, 8'h00, 8'h00, 8'h00, 3'd0, 4'd0, 8'h00, 32'd1043);
        // foreign clients
        send_item(ACT_BEACON, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 4'd3, 8'h64, 32'd1044);
        send_item(ACT_BEACON, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 4'd3, 8'h64, 32'd1045);

        run_phase(3'd1, 3'd0, 16'd0, 16'd1000, 8'hBC, 70, 1'b0, 1'b0);
        run_phase(3'd4, 3'd7, 16'd0, 16'd0, 8'h7F, 70, 1'b1, 1'b0);
        run_phase(3'd2, 3'd3, 16'd1, 16'd0, 8'h80, 70, 1'b0, 1'b1);
        run_phase(3'd3, 3'd1, 16'd3, 16'd50, 8'hC4, 70, 1'b0, 1'b0);
        run_phase(3'd1, 3'd5, 16'd0, 16'hFFFF, 8'hD8, 70, 1'b0, 1'b0);
        run_phase(3'd2, 3'd2, 16'hFFFF, 16'd100, 8'h00, 40, 1'b0, 1'b0);
        run_phase(3'd7, 3'd4, 16'd0, 16'd1000, 8'hBA, 30, 1'b0, 1'b0);
        run_phase(3'd1, 3'd0, 16'd0, 16'd200, 8'hEC, 80, 1'b0, 1'b0);

        drain();
        if (mismatch_count == 0 && msgs_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
